// ----- sv/aes_pkg.sv -----
// ----------------------------------------------------------------------------
// AES-128 package
// S-box table, byte helpers and one-round functions shared by the datapath.
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int ROUNDS_DEF = 10;
    localparam int BLK_W      = 128;
    localparam int HALF_W     = 64;
    localparam int CFG_IDX_W  = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b1;

    typedef logic [BLK_W-1:0] t_block;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] r;
        case (a)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // byte n of a block sits at bits 127-8n .. 120-8n
    function automatic logic [7:0] get_byte(input t_block b, input int n);
        return b[BLK_W-1-8*n -: 8];
    endfunction

    // Next round key from the current one, rc is the round constant
    function automatic t_block next_key(input t_block k, input logic [7:0] rc);
        logic [7:0] t [4];
        t_block     o;
        t[0] = sbox(get_byte(k, 13)) ^ rc;
        t[1] = sbox(get_byte(k, 14));
        t[2] = sbox(get_byte(k, 15));
        t[3] = sbox(get_byte(k, 12));
        for (int i = 0; i < 16; i++) begin
            o[BLK_W-1-8*i -: 8] = get_byte(k, i) ^ t[i % 4];
            t[i % 4] = o[BLK_W-1-8*i -: 8];
        end
        return o;
    endfunction

    // SubBytes and ShiftRows
    function automatic t_block sub_shift(input t_block s);
        t_block o;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                o[BLK_W-1-8*(r+4*c) -: 8] = sbox(get_byte(s, r + 4*((c + r) % 4)));
        return o;
    endfunction

    function automatic t_block mix_columns(input t_block s);
        t_block     o;
        logic [7:0] a0, a1, a2, a3, al;
        for (int c = 0; c < 4; c++) begin
            a0 = get_byte(s, 4*c);
            a1 = get_byte(s, 4*c+1);
            a2 = get_byte(s, 4*c+2);
            a3 = get_byte(s, 4*c+3);
            al = a0 ^ a1 ^ a2 ^ a3;
            o[BLK_W-1-8*(4*c)   -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
            o[BLK_W-1-8*(4*c+1) -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
            o[BLK_W-1-8*(4*c+2) -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
            o[BLK_W-1-8*(4*c+3) -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
        end
        return o;
    endfunction

endpackage

// ----- sv/aes_round.sv -----
// ----------------------------------------------------------------------------
// AES round stage
// One registered cipher round with its key expansion step, plus stall control.
// ----------------------------------------------------------------------------
module aes_round #(
    parameter logic [7:0] RCON  = 8'h01,
    parameter bit         LAST  = 1'b0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  aes_pkg::t_block i_state,
    input  aes_pkg::t_block i_key,
    output logic          o_valid,
    output aes_pkg::t_block o_state,
    output aes_pkg::t_block o_key
);
    import aes_pkg::*;

    t_block n_key;
    t_block n_state;
    t_block r_state;
    t_block r_key;
    logic   r_valid;

    // round datapath
    always_comb begin
        n_key   = next_key(i_key, RCON);
        n_state = LAST ? sub_shift(i_state) : mix_columns(sub_shift(i_state));
        n_state = n_state ^ n_key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_state <= n_state;
            r_key   <= n_key;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;
    assign o_key   = r_key;
endmodule

// ----- sv/aes128_block_encrypt.sv -----
// ----------------------------------------------------------------------------
// AES-128 block encrypt
// Fully pipelined ECB encryption, one block per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   Config channel (i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data) loads
//   key_high (index 0) and key_low (index 1); other indexes are ignored.
//   Always ready out of reset. Write keys only while the pipeline is empty.
//   Input channel i_valid/o_ready carries a plaintext block; output channel
//   o_valid/i_ready returns its ciphertext.
//   ROUNDS+1 register stages lie between input transfer and output valid:
//   the initial key add, then one per round. Throughput: one block per cycle
//   while the output is not stalled. The key schedule runs alongside the data.
//   Each stage advances on its own: when the output register holds a result
//   that is not taken, o_ready drops only if that stall backs up into a full
//   pipe; empty stages still fill, so bubbles are squeezed out.
//   Reset clears all valid bits and both key registers to zero; all ready
//   and valid outputs are low while reset is held.
// ----------------------------------------------------------------------------
module aes128_block_encrypt #(
    parameter int ROUNDS = aes_pkg::ROUNDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [aes_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [aes_pkg::HALF_W-1:0]    i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [aes_pkg::HALF_W-1:0]    i_block_high,
    input  logic [aes_pkg::HALF_W-1:0]    i_block_low,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [aes_pkg::HALF_W-1:0]    o_cipher_high,
    output logic [aes_pkg::HALF_W-1:0]    o_cipher_low
);
    import aes_pkg::*;

    logic [HALF_W-1:0] r_key_high;
    logic [HALF_W-1:0] r_key_low;

    // stage 0 is the initial key add, stage ROUNDS is the output register
    logic   v   [ROUNDS+1];
    t_block st  [ROUNDS+1];
    t_block ky  [ROUNDS+1];
    logic   en  [ROUNDS+1];
    logic   r_v0;
    t_block r_s0;
    t_block r_k0;

    // key registers
    assign o_cfg_ready = i_rst_n;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_KEY_HIGH: r_key_high <= i_cfg_data;
                REG_KEY_LOW:  r_key_low  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // per-stage advance: a stage loads when its holder is empty or moving on
    always_comb begin
        en[ROUNDS] = i_ready || !v[ROUNDS];
        for (int i = ROUNDS - 1; i >= 0; i--)
            en[i] = en[i+1] || !v[i];
    end

    assign o_ready = en[0] && i_rst_n;

    // stage 0: initial AddRoundKey
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en[0]) begin
            r_v0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_s0 <= {i_block_high, i_block_low} ^ {r_key_high, r_key_low};
            r_k0 <= {r_key_high, r_key_low};
        end
    end

    assign v[0]  = r_v0;
    assign st[0] = r_s0;
    assign ky[0] = r_k0;

    // round stages
    for (genvar g = 1; g <= ROUNDS; g++) begin : g_round
        localparam logic [7:0] RC = (g <= 8) ? 8'(1 << (g - 1)) : ((g == 9) ? 8'h1b : 8'h36);
        aes_round #(
            .RCON (RC),
            .LAST (g == ROUNDS)
        ) u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en[g]),
            .i_valid (v[g-1]),
            .i_state (st[g-1]),
            .i_key   (ky[g-1]),
            .o_valid (v[g]),
            .o_state (st[g]),
            .o_key   (ky[g])
        );
    end

    assign o_valid       = v[ROUNDS] && i_rst_n;
    assign o_cipher_high = st[ROUNDS][BLK_W-1:HALF_W];
    assign o_cipher_low  = st[ROUNDS][HALF_W-1:0];
endmodule

// ----- sv/aes_checker.sv -----
// ----------------------------------------------------------------------------
// AES port checker
// Port-level properties of the encrypt block, bound to the top level.
// ----------------------------------------------------------------------------
module aes_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_cfg_ready,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [63:0] o_cipher_high,
    input logic [63:0] o_cipher_low
);
    // key port never pushes back
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready) else $error("config port not ready");

    // output stalled: result held
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_cipher_high)
        && $stable(o_cipher_low)) else $error("stalled result changed");

    // receiver ready or output empty: input side open
    a_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ready || !o_valid) |-> o_ready) else $error("input blocked needlessly");

    // nothing comes out right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("valid out of reset");
endmodule

bind aes128_block_encrypt aes_checker u_aes_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_cfg_ready   (o_cfg_ready),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_cipher_high (o_cipher_high),
    .o_cipher_low  (o_cipher_low)
);
